// ----- hw/rtl/sec_pkg.sv -----
// ----------------------------------------------------------------------------
// sec_pkg: shared types and constants
// Field widths, stage counts and helpers for the sphere collision pipeline.
// ----------------------------------------------------------------------------
package sec_pkg;

  localparam int NAX   = 3;          // axes
  localparam int VW    = 32;         // Q16.16 field width
  localparam int DW    = VW + 1;     // coordinate difference
  localparam int AW    = 31;         // |d| on a contact
  localparam int SQW   = 2 * AW;     // d_i^2 on a contact
  localparam int D2W   = 64;         // sum of squares
  localparam int SW    = 66;         // signed dot product (v2 - v1).d
  localparam int MAGW  = SW - 1;     // |s|
  localparam int MW    = 16;         // mass width
  localparam int MSW   = MW + 1;     // mass sum / doubled mass
  localparam int CDW   = 31;         // contact distance width
  localparam int CD2W  = 2 * CDW;
  localparam int BASEW = MAGW + AW;  // |s| * |d_i|
  localparam int NUMW  = BASEW + MSW;
  localparam int DENW  = SQW + MSW;  // d2 * (m1 + m2)
  localparam int QW    = 32;         // quotient bits below the clamp
  localparam int REMW  = DENW + QW;
  localparam int CIW   = 2;          // config index width

  localparam int FRONT_STAGES = 8;
  localparam int DIV_STAGES   = QW + 1;
  localparam int N_STAGES     = FRONT_STAGES + DIV_STAGES + 1;

  localparam logic [MW-1:0]  FIRST_MASS_RST       = MW'(256);
  localparam logic [MW-1:0]  SECOND_MASS_RST      = MW'(256);
  localparam logic [CDW-1:0] CONTACT_DISTANCE_RST = CDW'(131072);

  typedef enum logic [CIW-1:0] {
    CFG_FIRST_MASS       = 2'd0,
    CFG_SECOND_MASS      = 2'd1,
    CFG_CONTACT_DISTANCE = 2'd2
  } cfg_idx_t;

  typedef logic [NAX-1:0][VW-1:0] vec_t;

  typedef struct packed {
    vec_t v1;
    vec_t v2;
  } pass_t;

  typedef struct packed {
    logic           hit;
    logic [NAX-1:0] flip;
    vec_t           v1;
    vec_t           v2;
  } side_t;

  // Clamp a widened signed sum to the 32-bit field range.
  function automatic logic [VW-1:0] sat(input logic signed [VW+2:0] x);
    logic [VW-1:0] r;
    if ((x[VW+2:VW-1] == '0) || (x[VW+2:VW-1] == '1)) begin
      r = x[VW-1:0];
    end else if (x[VW+2]) begin
      r = {1'b1, {(VW-1){1'b0}}};
    end else begin
      r = {1'b0, {(VW-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/sec_in_if.sv -----
// ----------------------------------------------------------------------------
// sec_in_if: sphere pair channel
// Valid/ready channel carrying both centres and both velocities.
// ----------------------------------------------------------------------------
interface sec_in_if;
  logic                         valid;
  logic                         ready;
  logic signed [sec_pkg::VW-1:0] first_pos_x;
  logic signed [sec_pkg::VW-1:0] first_pos_y;
  logic signed [sec_pkg::VW-1:0] first_pos_z;
  logic signed [sec_pkg::VW-1:0] second_pos_x;
  logic signed [sec_pkg::VW-1:0] second_pos_y;
  logic signed [sec_pkg::VW-1:0] second_pos_z;
  logic signed [sec_pkg::VW-1:0] first_vel_x;
  logic signed [sec_pkg::VW-1:0] first_vel_y;
  logic signed [sec_pkg::VW-1:0] first_vel_z;
  logic signed [sec_pkg::VW-1:0] second_vel_x;
  logic signed [sec_pkg::VW-1:0] second_vel_y;
  logic signed [sec_pkg::VW-1:0] second_vel_z;

  modport source (
    output valid, first_pos_x, first_pos_y, first_pos_z,
    output second_pos_x, second_pos_y, second_pos_z,
    output first_vel_x, first_vel_y, first_vel_z,
    output second_vel_x, second_vel_y, second_vel_z,
    input  ready
  );
  modport sink (
    input  valid, first_pos_x, first_pos_y, first_pos_z,
    input  second_pos_x, second_pos_y, second_pos_z,
    input  first_vel_x, first_vel_y, first_vel_z,
    input  second_vel_x, second_vel_y, second_vel_z,
    output ready
  );
endinterface

// ----- hw/rtl/sec_out_if.sv -----
// ----------------------------------------------------------------------------
// sec_out_if: collision result channel
// Valid/ready channel carrying the hit flag and both new velocities.
// ----------------------------------------------------------------------------
interface sec_out_if;
  logic                         valid;
  logic                         ready;
  logic                         hit;
  logic signed [sec_pkg::VW-1:0] new_first_vel_x;
  logic signed [sec_pkg::VW-1:0] new_first_vel_y;
  logic signed [sec_pkg::VW-1:0] new_first_vel_z;
  logic signed [sec_pkg::VW-1:0] new_second_vel_x;
  logic signed [sec_pkg::VW-1:0] new_second_vel_y;
  logic signed [sec_pkg::VW-1:0] new_second_vel_z;

  modport source (
    output valid, hit, new_first_vel_x, new_first_vel_y, new_first_vel_z,
    output new_second_vel_x, new_second_vel_y, new_second_vel_z,
    input  ready
  );
  modport sink (
    input  valid, hit, new_first_vel_x, new_first_vel_y, new_first_vel_z,
    input  new_second_vel_x, new_second_vel_y, new_second_vel_z,
    output ready
  );
endinterface

// ----- hw/rtl/sphere_elastic_collision.sv -----
// Pipeline: 42 stages (8 product stages, 33 restoring-divider stages, one
// saturation stage) from an input transfer to its result on the output register.
// Throughput: one sphere pair per cycle while the output is ready.
// Stalls collapse bubbles stage by stage; a full pipe holds until the result moves.
// Synchronous reset empties the pipeline and loads both masses with 1.0 and the
// contact distance with 2.0.
// ----------------------------------------------------------------------------
// sphere_elastic_collision: 3-D elastic collision of two spheres
// Contact test on squared distance, then mass-weighted exchange along the
// centre line, saturated to the Q16.16 range.
// ----------------------------------------------------------------------------
module sphere_elastic_collision (
  input  logic                      clk,
  input  logic                      rst,
  sec_in_if.sink                    sample,
  sec_out_if.source                 result,
  input  logic                      cfg_we,
  input  logic [sec_pkg::CIW-1:0]   cfg_index,
  input  logic [sec_pkg::CDW-1:0]   cfg_data
);

  localparam int N   = sec_pkg::N_STAGES;
  localparam int F   = sec_pkg::FRONT_STAGES;
  localparam int NS  = sec_pkg::DIV_STAGES;
  localparam int NAX = sec_pkg::NAX;
  localparam int VW  = sec_pkg::VW;

  logic [sec_pkg::MW-1:0]  first_mass;
  logic [sec_pkg::MW-1:0]  second_mass;
  logic [sec_pkg::CDW-1:0] contact_distance;

  logic [N-1:0] v;
  logic [N-1:0] en;

  sec_pkg::vec_t p1, p2, v1, v2;
  logic [NAX-1:0][sec_pkg::NUMW-1:0] num1, num2;
  logic [sec_pkg::DENW-1:0] den;
  sec_pkg::side_t side;
  sec_pkg::side_t sd [NS];

  logic [NAX-1:0][sec_pkg::QW-1:0] q1, q2;
  logic [NAX-1:0] big1, big2;

  logic           hit;
  sec_pkg::vec_t  nv1, nv2;
  sec_pkg::vec_t  nv1_next, nv2_next;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      first_mass       <= sec_pkg::FIRST_MASS_RST;
      second_mass      <= sec_pkg::SECOND_MASS_RST;
      contact_distance <= sec_pkg::CONTACT_DISTANCE_RST;
    end else if (cfg_we) begin
      case (sec_pkg::cfg_idx_t'(cfg_index))
        sec_pkg::CFG_FIRST_MASS:       first_mass       <= cfg_data[sec_pkg::MW-1:0];
        sec_pkg::CFG_SECOND_MASS:      second_mass      <= cfg_data[sec_pkg::MW-1:0];
        sec_pkg::CFG_CONTACT_DISTANCE: contact_distance <= cfg_data;
        default: ;
      endcase
    end
  end

  // a stage advances when some stage at or after it is empty, or the output drains
  for (genvar k = 0; k < N; k++) begin : g_en
    assign en[k] = result.ready || !(&v[N-1:k]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= sample.valid;
      end
      for (int k = 1; k < N; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  assign sample.ready = en[0];

  assign p1 = {sample.first_pos_z,  sample.first_pos_y,  sample.first_pos_x};
  assign p2 = {sample.second_pos_z, sample.second_pos_y, sample.second_pos_x};
  assign v1 = {sample.first_vel_z,  sample.first_vel_y,  sample.first_vel_x};
  assign v2 = {sample.second_vel_z, sample.second_vel_y, sample.second_vel_x};

  sec_front u_front (
    .clk              (clk),
    .en               (en[F-1:0]),
    .p1               (p1),
    .p2               (p2),
    .v1               (v1),
    .v2               (v2),
    .first_mass       (first_mass),
    .second_mass      (second_mass),
    .contact_distance (contact_distance),
    .num1             (num1),
    .num2             (num2),
    .den              (den),
    .side             (side)
  );

  for (genvar i = 0; i < NAX; i++) begin : g_axis
    sec_div u_div1 (
      .clk (clk),
      .en  (en[F+NS-1:F]),
      .num (num1[i]),
      .den (den),
      .q   (q1[i]),
      .big (big1[i])
    );
    sec_div u_div2 (
      .clk (clk),
      .en  (en[F+NS-1:F]),
      .num (num2[i]),
      .den (den),
      .q   (q2[i]),
      .big (big2[i])
    );
  end

  // carry flags and input velocities alongside the dividers
  always_ff @(posedge clk) begin
    if (en[F]) begin
      sd[0] <= side;
    end
    for (int j = 1; j < NS; j++) begin
      if (en[F+j]) begin
        sd[j] <= sd[j-1];
      end
    end
  end

  // apply the clamped change and saturate
  always_comb begin
    logic [VW:0]            c1, c2;
    logic signed [VW+2:0]   d1, d2;
    for (int i = 0; i < NAX; i++) begin
      c1 = big1[i] ? {1'b1, {VW{1'b0}}} : {1'b0, q1[i]};
      c2 = big2[i] ? {1'b1, {VW{1'b0}}} : {1'b0, q2[i]};
      d1 = sd[NS-1].flip[i] ? -$signed({2'b00, c1}) : $signed({2'b00, c1});
      d2 = sd[NS-1].flip[i] ? -$signed({2'b00, c2}) : $signed({2'b00, c2});
      nv1_next[i] = sec_pkg::sat($signed({{3{sd[NS-1].v1[i][VW-1]}}, sd[NS-1].v1[i]}) + d1);
      nv2_next[i] = sec_pkg::sat($signed({{3{sd[NS-1].v2[i][VW-1]}}, sd[NS-1].v2[i]}) - d2);
    end
  end

  always_ff @(posedge clk) begin
    if (en[N-1]) begin
      hit <= sd[NS-1].hit;
      nv1 <= sd[NS-1].hit ? nv1_next : sd[NS-1].v1;
      nv2 <= sd[NS-1].hit ? nv2_next : sd[NS-1].v2;
    end
  end

  assign result.valid            = v[N-1];
  assign result.hit              = hit;
  assign result.new_first_vel_x  = nv1[0];
  assign result.new_first_vel_y  = nv1[1];
  assign result.new_first_vel_z  = nv1[2];
  assign result.new_second_vel_x = nv2[0];
  assign result.new_second_vel_y = nv2[1];
  assign result.new_second_vel_z = nv2[2];

  a_fill_first: assert property (@(posedge clk) disable iff (rst)
    (sample.valid && sample.ready) |=> v[0])
    else $error("transfer in did not fill the first stage");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (sample.valid && sample.ready && !(result.valid && result.ready))
      |=> $countones(v) == $countones($past(v)) + 1)
    else $error("item lost or invented on input transfer");

  a_count_down: assert property (@(posedge clk) disable iff (rst)
    (!(sample.valid && sample.ready) && result.valid && result.ready)
      |=> $countones(v) + 1 == $countones($past(v)))
    else $error("item lost or invented on output transfer");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    (!sample.valid && !result.ready) |=> $countones(v) == $countones($past(v)))
    else $error("item count changed while both sides idle");

endmodule

// ----- hw/rtl/sec_front.sv -----
// ----------------------------------------------------------------------------
// sec_front: geometry and product stages
// Eight stages: differences, squares and dot terms, sums, contact test,
// then the numerators and the common divisor in split partial products.
// ----------------------------------------------------------------------------
module sec_front (
  input  logic                                      clk,
  input  logic [sec_pkg::FRONT_STAGES-1:0]          en,
  input  sec_pkg::vec_t                             p1,
  input  sec_pkg::vec_t                             p2,
  input  sec_pkg::vec_t                             v1,
  input  sec_pkg::vec_t                             v2,
  input  logic [sec_pkg::MW-1:0]                    first_mass,
  input  logic [sec_pkg::MW-1:0]                    second_mass,
  input  logic [sec_pkg::CDW-1:0]                   contact_distance,
  output logic [sec_pkg::NAX-1:0][sec_pkg::NUMW-1:0] num1,
  output logic [sec_pkg::NAX-1:0][sec_pkg::NUMW-1:0] num2,
  output logic [sec_pkg::DENW-1:0]                  den,
  output sec_pkg::side_t                            side
);

  localparam int NAX = sec_pkg::NAX;
  localparam int VW  = sec_pkg::VW;
  localparam int DW  = sec_pkg::DW;
  localparam int AW  = sec_pkg::AW;
  localparam int HLF = sec_pkg::SQW / 2;
  localparam int MLO = DW;                  // low split of |s|
  localparam int CW  = VW;                  // numerator chunk width

  // stage 0
  logic signed [DW-1:0] s0_d [NAX];
  logic signed [DW-1:0] s0_vd [NAX];
  sec_pkg::pass_t       s0_pass;

  // stage 1
  logic [sec_pkg::SQW-1:0]     s1_sq [NAX];
  logic signed [sec_pkg::SW-1:0] s1_pr [NAX];
  logic [AW-1:0]               s1_ad [NAX];
  logic [NAX-1:0]              s1_near;
  logic [NAX-1:0]              s1_dneg;
  logic [sec_pkg::CD2W-1:0]    s1_cd2;
  logic [sec_pkg::MSW-1:0]     s1_msum;
  sec_pkg::pass_t              s1_pass;

  // stage 2
  logic [sec_pkg::D2W-1:0]     s2_d2;
  logic signed [sec_pkg::SW-1:0] s2_s;
  logic                        s2_hit0;
  logic [AW-1:0]               s2_ad [NAX];
  logic [NAX-1:0]              s2_dneg;
  logic [sec_pkg::CD2W-1:0]    s2_cd2;
  logic [sec_pkg::MSW-1:0]     s2_msum;
  sec_pkg::pass_t              s2_pass;

  // stage 3
  logic                        s3_hit;
  logic [NAX-1:0]              s3_flip;
  logic [sec_pkg::MAGW-1:0]    s3_mag;
  logic [HLF+sec_pkg::MSW-1:0] s3_dlo;
  logic [HLF+sec_pkg::MSW-1:0] s3_dhi;
  logic [AW-1:0]               s3_ad [NAX];
  sec_pkg::pass_t              s3_pass;

  // stage 4
  logic                        s4_hit;
  logic [NAX-1:0]              s4_flip;
  logic [MLO+AW-1:0]           s4_blo [NAX];
  logic [sec_pkg::MAGW-MLO+AW-1:0] s4_bhi [NAX];
  logic [sec_pkg::DENW-1:0]    s4_den;
  sec_pkg::pass_t              s4_pass;

  // stage 5
  logic                        s5_hit;
  logic [NAX-1:0]              s5_flip;
  logic [sec_pkg::BASEW-1:0]   s5_base [NAX];
  logic [sec_pkg::DENW-1:0]    s5_den;
  sec_pkg::pass_t              s5_pass;

  // stage 6
  logic                        s6_hit;
  logic [NAX-1:0]              s6_flip;
  logic [CW+sec_pkg::MSW-1:0]  s6_n1 [NAX][3];
  logic [CW+sec_pkg::MSW-1:0]  s6_n2 [NAX][3];
  logic [sec_pkg::DENW-1:0]    s6_den;
  sec_pkg::pass_t              s6_pass;

  // combinational helpers
  logic [DW-1:0]                s0_abs [NAX];
  logic signed [2*DW-1:0]       s0_sqf [NAX];
  logic signed [2*DW-1:0]       s0_prf [NAX];
  logic [2*sec_pkg::CDW-1:0]    cd_sq;
  logic signed [sec_pkg::SW-1:0] s2_neg;
  logic [sec_pkg::MSW-1:0]      tm1;
  logic [sec_pkg::MSW-1:0]      tm2;

  assign cd_sq = contact_distance * contact_distance;
  assign s2_neg = -s2_s;
  assign tm1 = {first_mass, 1'b0};
  assign tm2 = {second_mass, 1'b0};

  always_comb begin
    for (int i = 0; i < NAX; i++) begin
      s0_abs[i] = s0_d[i][DW-1] ? DW'(-s0_d[i]) : DW'(s0_d[i]);
      s0_sqf[i] = s0_d[i] * s0_d[i];
      s0_prf[i] = s0_vd[i] * s0_d[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < NAX; i++) begin
        s0_d[i]  <= $signed({p2[i][VW-1], p2[i]}) - $signed({p1[i][VW-1], p1[i]});
        s0_vd[i] <= $signed({v2[i][VW-1], v2[i]}) - $signed({v1[i][VW-1], v1[i]});
      end
      s0_pass <= '{v1: v1, v2: v2};
    end

    if (en[1]) begin
      for (int i = 0; i < NAX; i++) begin
        s1_sq[i]   <= s0_sqf[i][sec_pkg::SQW-1:0];
        s1_pr[i]   <= s0_prf[i][sec_pkg::SW-1:0];
        s1_ad[i]   <= s0_abs[i][AW-1:0];
        s1_near[i] <= s0_abs[i] <= DW'(contact_distance);
        s1_dneg[i] <= s0_d[i][DW-1];
      end
      s1_cd2  <= cd_sq;
      s1_msum <= {1'b0, first_mass} + {1'b0, second_mass};
      s1_pass <= s0_pass;
    end

    if (en[2]) begin
      s2_d2   <= sec_pkg::D2W'(s1_sq[0]) + sec_pkg::D2W'(s1_sq[1])
               + sec_pkg::D2W'(s1_sq[2]);
      s2_s    <= s1_pr[0] + s1_pr[1] + s1_pr[2];
      s2_hit0 <= &s1_near;
      s2_ad   <= s1_ad;
      s2_dneg <= s1_dneg;
      s2_cd2  <= s1_cd2;
      s2_msum <= s1_msum;
      s2_pass <= s1_pass;
    end

    if (en[3]) begin
      s3_hit  <= s2_hit0 && (s2_d2 <= sec_pkg::D2W'(s2_cd2)) && (s2_d2 != '0)
                 && (s2_msum != '0);
      s3_flip <= s2_dneg ^ {NAX{s2_s[sec_pkg::SW-1]}};
      s3_mag  <= s2_s[sec_pkg::SW-1] ? s2_neg[sec_pkg::MAGW-1:0]
                                     : s2_s[sec_pkg::MAGW-1:0];
      s3_dlo  <= s2_d2[HLF-1:0] * s2_msum;
      s3_dhi  <= s2_d2[2*HLF-1:HLF] * s2_msum;
      s3_ad   <= s2_ad;
      s3_pass <= s2_pass;
    end

    if (en[4]) begin
      for (int i = 0; i < NAX; i++) begin
        s4_blo[i] <= s3_mag[MLO-1:0] * s3_ad[i];
        s4_bhi[i] <= s3_mag[sec_pkg::MAGW-1:MLO] * s3_ad[i];
      end
      s4_den  <= sec_pkg::DENW'(s3_dlo) + (sec_pkg::DENW'(s3_dhi) << HLF);
      s4_hit  <= s3_hit;
      s4_flip <= s3_flip;
      s4_pass <= s3_pass;
    end

    if (en[5]) begin
      for (int i = 0; i < NAX; i++) begin
        s5_base[i] <= sec_pkg::BASEW'(s4_blo[i]) + (sec_pkg::BASEW'(s4_bhi[i]) << MLO);
      end
      s5_den  <= s4_den;
      s5_hit  <= s4_hit;
      s5_flip <= s4_flip;
      s5_pass <= s4_pass;
    end

    if (en[6]) begin
      for (int i = 0; i < NAX; i++) begin
        for (int c = 0; c < 3; c++) begin
          s6_n1[i][c] <= s5_base[i][c*CW +: CW] * tm2;
          s6_n2[i][c] <= s5_base[i][c*CW +: CW] * tm1;
        end
      end
      s6_den  <= s5_den;
      s6_hit  <= s5_hit;
      s6_flip <= s5_flip;
      s6_pass <= s5_pass;
    end

    if (en[7]) begin
      for (int i = 0; i < NAX; i++) begin
        num1[i] <= sec_pkg::NUMW'(s6_n1[i][0])
                 + (sec_pkg::NUMW'(s6_n1[i][1]) << CW)
                 + (sec_pkg::NUMW'(s6_n1[i][2]) << (2 * CW));
        num2[i] <= sec_pkg::NUMW'(s6_n2[i][0])
                 + (sec_pkg::NUMW'(s6_n2[i][1]) << CW)
                 + (sec_pkg::NUMW'(s6_n2[i][2]) << (2 * CW));
      end
      den  <= s6_den;
      side <= '{hit: s6_hit, flip: s6_flip, v1: s6_pass.v1, v2: s6_pass.v2};
    end
  end

endmodule

// ----- hw/rtl/sec_div.sv -----
// ----------------------------------------------------------------------------
// sec_div: pipelined restoring divider
// First stage flags a quotient of 2^32 or more; the next 32 stages each
// resolve one quotient bit by a trial subtract.
// ----------------------------------------------------------------------------
module sec_div (
  input  logic                             clk,
  input  logic [sec_pkg::DIV_STAGES-1:0]   en,
  input  logic [sec_pkg::NUMW-1:0]         num,
  input  logic [sec_pkg::DENW-1:0]         den,
  output logic [sec_pkg::QW-1:0]           q,
  output logic                             big
);

  localparam int QW   = sec_pkg::QW;
  localparam int REMW = sec_pkg::REMW;
  localparam int NS   = sec_pkg::DIV_STAGES;

  logic [REMW-1:0]          rem_r [NS];
  logic [sec_pkg::DENW-1:0] den_r [NS];
  logic [QW-1:0]            q_r   [NS];
  logic                     big_r [NS];
  logic                     big0;

  assign big0 = sec_pkg::NUMW'(num) >= (sec_pkg::NUMW'(den) << QW);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      rem_r[0] <= num[REMW-1:0];
      den_r[0] <= den;
      q_r[0]   <= '0;
      big_r[0] <= big0;
    end
  end

  for (genvar j = 1; j < NS; j++) begin : g_step
    localparam int K = QW - j;
    logic [REMW:0] trial;
    assign trial = {1'b0, rem_r[j-1]} - ((REMW+1)'(den_r[j-1]) << K);

    always_ff @(posedge clk) begin
      if (en[j]) begin
        rem_r[j] <= trial[REMW] ? rem_r[j-1] : trial[REMW-1:0];
        q_r[j]   <= {q_r[j-1][QW-2:0], !trial[REMW]};
        den_r[j] <= den_r[j-1];
        big_r[j] <= big_r[j-1];
      end
    end
  end

  assign q   = q_r[NS-1];
  assign big = big_r[NS-1];

endmodule
